/* rtl/lru_memo_table_unit_assert.svh */
// ---------------------------------------------------------------------------
// lru memo table assertion macros
// shared property wrappers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef LRU_MEMO_TABLE_UNIT_ASSERT_SVH
`define LRU_MEMO_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lmt_pkg.sv */
// ---------------------------------------------------------------------------
// lmt_pkg
// types and codes shared by the lru memo table controller and datapath
// ---------------------------------------------------------------------------
package lmt_pkg;

    localparam int KEY_W   = 64;
    localparam int DATA_W  = 64;
    localparam int AGE_W   = 64;
    localparam int CNT_W   = 32;
    localparam int ENTRY_W = KEY_W + DATA_W + AGE_W;

    // request kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_NO_EVICTION = 1'b1;

    typedef enum logic [1:0] {
        SCAN_LOOKUP,
        SCAN_OLDEST,
        SCAN_SHIFT
    } t_scan_mode;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [AGE_W-1:0]  age;
    } t_entry;

    typedef struct packed {
        logic       latch;
        logic       scan_init;
        logic       scan_from_best;
        logic       scan_run;
        t_scan_mode scan_mode;
        logic       append;
        logic       vt_dec;
        logic       serial_inc;
        logic       hit_wb;
        logic       miss_inc;
        logic       clear;
        logic       set_status;
        logic [1:0] status_code;
    } t_lmt_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       no_evict;
        logic       limit_zero;
        logic       full;
        logic       vt_zero;
        logic       over_limit;
        logic       scan_done;
        logic       match;
        logic       keep_new;
    } t_lmt_stat;

endpackage

/* rtl/lmt_ram.sv */
// ---------------------------------------------------------------------------
// lmt_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module lmt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lmt_ctrl.sv */
// ---------------------------------------------------------------------------
// lmt_ctrl
// request sequencer: lookup scan, append, oldest search and shift-down
// ---------------------------------------------------------------------------
module lmt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lmt_pkg::t_lmt_stat i_stat,
    output lmt_pkg::t_lmt_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_result_valid
);

    import lmt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LK_SCAN,
        S_LK_HIT,
        S_FL_APPEND,
        S_FL_CHECK,
        S_EV_SCAN,
        S_EV_CHECK,
        S_SH_RUN
    } t_state;

    t_state   r_state, n_state;
    logic     r_busy, n_busy;
    logic     r_done, n_done;
    logic     r_full_path, n_full_path;
    t_lmt_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_done      = 1'b0;
        n_full_path = r_full_path;
        cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                    n_busy    = 1'b1;
                end
            end
            S_DECODE: begin
                n_full_path = 1'b0;
                case (i_stat.kind)
                    KIND_LOOKUP: begin
                        if (i_stat.vt_zero) begin
                            cmd.miss_inc = 1'b1;
                            n_state      = S_IDLE;
                            n_busy       = 1'b0;
                            n_done       = 1'b1;
                        end else begin
                            cmd.scan_init = 1'b1;
                            n_state       = S_LK_SCAN;
                        end
                    end
                    KIND_FILL: begin
                        if (i_stat.no_evict) begin
                            if (i_stat.full) begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = STATUS_DROPPED;
                                n_state         = S_IDLE;
                                n_busy          = 1'b0;
                                n_done          = 1'b1;
                            end else begin
                                cmd.serial_inc = 1'b1;
                                n_state        = S_FL_APPEND;
                            end
                        end else if (i_stat.limit_zero) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STATUS_IGNORED;
                            n_state         = S_IDLE;
                            n_busy          = 1'b0;
                            n_done          = 1'b1;
                        end else begin
                            cmd.serial_inc = 1'b1;
                            if (i_stat.full) begin
                                // new entry competes with the old ones before any shift
                                n_full_path   = 1'b1;
                                cmd.scan_init = 1'b1;
                                n_state       = S_EV_SCAN;
                            end else begin
                                n_state = S_FL_APPEND;
                            end
                        end
                    end
                    KIND_CLEAR: begin
                        cmd.clear = 1'b1;
                        n_state   = S_IDLE;
                        n_busy    = 1'b0;
                        n_done    = 1'b1;
                    end
                    default: begin
                        n_state = S_IDLE;
                        n_busy  = 1'b0;
                        n_done  = 1'b1;
                    end
                endcase
            end
            S_LK_SCAN: begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_LOOKUP;
                if (i_stat.match) begin
                    n_state = S_LK_HIT;
                end else if (i_stat.scan_done) begin
                    cmd.miss_inc = 1'b1;
                    n_state      = S_IDLE;
                    n_busy       = 1'b0;
                    n_done       = 1'b1;
                end
            end
            S_LK_HIT: begin
                cmd.hit_wb     = 1'b1;
                cmd.serial_inc = 1'b1;
                n_state        = S_IDLE;
                n_busy         = 1'b0;
                n_done         = 1'b1;
            end
            S_FL_APPEND: begin
                cmd.append = 1'b1;
                n_state    = S_FL_CHECK;
            end
            S_FL_CHECK: begin
                if (!r_full_path && !i_stat.no_evict && i_stat.over_limit) begin
                    cmd.scan_init = 1'b1;
                    n_state       = S_EV_SCAN;
                end else begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end
            end
            S_EV_SCAN: begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_OLDEST;
                if (i_stat.scan_done) begin
                    n_state = S_EV_CHECK;
                end
            end
            S_EV_CHECK: begin
                if (r_full_path && i_stat.keep_new) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_done  = 1'b1;
                end else begin
                    cmd.scan_init      = 1'b1;
                    cmd.scan_from_best = 1'b1;
                    n_state            = S_SH_RUN;
                end
            end
            S_SH_RUN: begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_SHIFT;
                if (i_stat.scan_done) begin
                    cmd.vt_dec = 1'b1;
                    if (r_full_path) begin
                        n_state = S_FL_APPEND;
                    end else begin
                        n_state = S_IDLE;
                        n_busy  = 1'b0;
                        n_done  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_full_path <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_full_path <= n_full_path;
        end
    end

    assign o_cmd          = cmd;
    assign o_busy         = r_busy;
    assign o_result_valid = r_done;

endmodule

/* rtl/lmt_datapath.sv */
// ---------------------------------------------------------------------------
// lmt_datapath
// entry ram, scan pipeline, counters, configuration and result registers
// ---------------------------------------------------------------------------
module lmt_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lmt_pkg::t_lmt_cmd  i_cmd,
    output lmt_pkg::t_lmt_stat o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_wdata,
    input  logic [1:0]         i_kind,
    input  logic [63:0]        i_lookup_key,
    input  logic [63:0]        i_fill_value,
    output logic               o_hit,
    output logic [63:0]        o_hit_value,
    output logic [1:0]         o_status,
    output logic [31:0]        o_hit_count,
    output logic [31:0]        o_miss_count,
    output logic [7:0]         o_entry_count
);

    import lmt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // configuration
    logic [7:0]        r_max_entries;
    logic              r_no_evict;

    // request
    logic [1:0]        r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_value;

    // table state
    logic [CW-1:0]     r_vt;
    logic [AGE_W-1:0]  r_serial;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;

    // scan pipeline
    logic [CW-1:0]     r_rd_ptr;
    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;
    logic [AW-1:0]     r_best_idx;
    logic [AGE_W-1:0]  r_best_age;
    logic [AW-1:0]     r_sel_idx;
    logic [DATA_W-1:0] r_sel_value;

    // result
    logic              r_hit;
    logic [DATA_W-1:0] r_hit_value;
    logic [1:0]        r_status;

    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    t_entry             wr_entry;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic               rd_lt;
    logic               match;
    logic               shift_wr;
    logic               older;
    logic [XW-1:0]      vt_x;
    logic [XW-1:0]      max_x;

    assign rd_entry = t_entry'(ram_rdata);
    assign rd_lt    = r_rd_ptr < r_vt;
    assign match    = r_cmp_vld && (rd_entry.key == r_key);
    assign rd_en    = i_cmd.scan_run && rd_lt
                      && !((i_cmd.scan_mode == SCAN_LOOKUP) && match);
    assign shift_wr = i_cmd.scan_run && (i_cmd.scan_mode == SCAN_SHIFT) && r_cmp_vld;
    assign older    = (r_cmp_idx == AW'(0)) || (rd_entry.age < r_best_age);
    assign vt_x     = XW'(r_vt);
    assign max_x    = XW'(r_max_entries);

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_entry = '0;
        if (i_cmd.append) begin
            wr_en    = 1'b1;
            wr_addr  = r_vt[AW-1:0];
            wr_entry = '{key: r_key, value: r_value, age: r_serial};
        end else if (i_cmd.hit_wb) begin
            wr_en    = 1'b1;
            wr_addr  = r_sel_idx;
            wr_entry = '{key: r_key, value: r_sel_value, age: r_serial + AGE_W'(1)};
        end else if (shift_wr) begin
            // move entry down by one slot
            wr_en    = 1'b1;
            wr_addr  = r_cmp_idx - AW'(1);
            wr_entry = rd_entry;
        end
    end

    lmt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 8'd128;
            r_no_evict    <= 1'b0;
            r_vt          <= '0;
            r_serial      <= '0;
            r_hits        <= '0;
            r_misses      <= '0;
            r_cmp_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ENTRIES: r_max_entries <= i_cfg_wdata;
                    CFG_NO_EVICTION: r_no_evict    <= i_cfg_wdata[0];
                    default:         r_no_evict    <= r_no_evict;
                endcase
            end

            if (i_cmd.clear) begin
                r_vt <= '0;
            end else if (i_cmd.append) begin
                r_vt <= r_vt + CW'(1);
            end else if (i_cmd.vt_dec) begin
                r_vt <= r_vt - CW'(1);
            end

            if (i_cmd.clear) begin
                r_serial <= '0;
            end else if (i_cmd.serial_inc) begin
                r_serial <= r_serial + AGE_W'(1);
            end

            if (i_cmd.clear) begin
                r_hits <= '0;
            end else if (i_cmd.hit_wb && (r_hits != '1)) begin
                r_hits <= r_hits + CNT_W'(1);
            end

            if (i_cmd.clear) begin
                r_misses <= '0;
            end else if (i_cmd.miss_inc && (r_misses != '1)) begin
                r_misses <= r_misses + CNT_W'(1);
            end

            if (i_cmd.scan_init) begin
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= rd_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind      <= i_kind;
            r_key       <= i_lookup_key;
            r_value     <= i_fill_value;
            r_hit       <= 1'b0;
            r_hit_value <= '0;
            r_status    <= STATUS_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.hit_wb) begin
            r_hit       <= 1'b1;
            r_hit_value <= r_sel_value;
        end

        if (i_cmd.scan_init) begin
            r_rd_ptr <= i_cmd.scan_from_best ? (CW'(r_best_idx) + CW'(1)) : '0;
        end else if (rd_en) begin
            r_rd_ptr  <= r_rd_ptr + CW'(1);
            r_cmp_idx <= r_rd_ptr[AW-1:0];
        end

        if (i_cmd.scan_run && (i_cmd.scan_mode == SCAN_LOOKUP) && match) begin
            r_sel_idx   <= r_cmp_idx;
            r_sel_value <= rd_entry.value;
        end

        // first entry seeds the search, ties keep the earlier slot
        if (i_cmd.scan_run && (i_cmd.scan_mode == SCAN_OLDEST) && r_cmp_vld && older) begin
            r_best_idx <= r_cmp_idx;
            r_best_age <= rd_entry.age;
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.no_evict   = r_no_evict;
    assign o_stat.limit_zero = (r_max_entries == 8'd0);
    assign o_stat.full       = (r_vt == CAP_C);
    assign o_stat.vt_zero    = (r_vt == '0);
    assign o_stat.over_limit = vt_x > max_x;
    assign o_stat.scan_done  = !r_cmp_vld && !rd_lt;
    assign o_stat.match      = match;
    assign o_stat.keep_new   = r_serial < r_best_age;

    assign o_hit         = r_hit;
    assign o_hit_value   = r_hit_value;
    assign o_status      = r_status;
    assign o_hit_count   = r_hits;
    assign o_miss_count  = r_misses;
    assign o_entry_count = vt_x[7:0];

endmodule

/* rtl/lru_memo_table_unit.sv */
// ---------------------------------------------------------------------------
// lru_memo_table_unit
// fully associative memo table with least-recently-used replacement
// ---------------------------------------------------------------------------
// usage:
//   a request (lookup, fill or clear) is taken on a rising edge with start
//   high and busy low; the key and value ports are sampled at that edge
//   one result per request: o_result_valid is high for exactly one cycle
//   with hit, value, status and the counts; the receiver cannot stall it
//   busy drops in the same cycle the result shows, so the next request can
//   be taken while the result is on the ports
//   after accept the request is decoded; clear, unused kinds and an ignored
//   or dropped fill end there; a lookup scans the entries held and ends
//   early on a hit; a fill appends the entry and, when eviction is on and
//   the count passes max_entries, searches for the oldest entry and shifts
//   the entries above it down; a full table does this before the append
//   the entry ram has one read port: lookup, oldest search and shift-down
//   each visit one entry per cycle; one request is handled at a time
//   configuration writes (i_cfg_we) take effect at once; the user must do
//   them only while busy is low, which the block does not enforce; reset
//   empties the table, zeroes the counters and the serial and loads
//   max_entries 128, no_eviction 0
// ---------------------------------------------------------------------------
module lru_memo_table_unit #(
    parameter int CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_lookup_key,
    input  logic [63:0] i_fill_value,
    output logic        o_result_valid,
    output logic        o_hit,
    output logic [63:0] o_hit_value,
    output logic [1:0]  o_status,
    output logic [31:0] o_hit_count,
    output logic [31:0] o_miss_count,
    output logic [7:0]  o_entry_count
);

    import lmt_pkg::*;

    t_lmt_cmd  cmd;
    t_lmt_stat stat;

    lmt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    lmt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_lookup_key  (i_lookup_key),
        .i_fill_value  (i_fill_value),
        .o_hit         (o_hit),
        .o_hit_value   (o_hit_value),
        .o_status      (o_status),
        .o_hit_count   (o_hit_count),
        .o_miss_count  (o_miss_count),
        .o_entry_count (o_entry_count)
    );

endmodule

/* rtl/lmt_checker.sv */
// ---------------------------------------------------------------------------
// lmt_checker
// port-level checks on request acceptance and the result strobe
// ---------------------------------------------------------------------------
`include "lru_memo_table_unit_assert.svh"

module lmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic        o_hit,
    input logic [63:0] o_hit_value
);

    `LMT_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "request taken but busy low")
    `LMT_ASSERT_NEXT(a_strobe_single, o_result_valid, !o_result_valid, "result strobe repeated")
    `LMT_ASSERT_NOW(a_strobe_not_busy, o_result_valid, !busy, "result shown while busy")
    `LMT_ASSERT_NOW(a_miss_value_zero, o_result_valid && !o_hit, o_hit_value == 64'd0, "value without hit")

endmodule

bind lru_memo_table_unit lmt_checker u_lmt_checker (.*);
